@@ rtl/spq_pkg.sv @@
package spq_pkg;

    localparam int KEY_BITS     = 10;
    localparam int PAYLOAD_BITS = 32;
    localparam int RANK_BITS    = 4;
    localparam int COUNT_BITS   = 5;
    localparam int STATUS_BITS  = 2;
    localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

    localparam int DEPTH_DEFAULT = 16;

    // stream packing, lowest field first, padded to whole bytes
    localparam int S_TDATA_BITS = ((KEY_BITS + PAYLOAD_BITS + RANK_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((KEY_BITS + PAYLOAD_BITS + COUNT_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_READ_OK  = 2'd2,
        ST_RANK_BAD = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load_in;
        logic    init_pos;
        logic    rd_rank;
        logic    dec_pos;
        logic    wr_shift;
        logic    wr_new;
        logic    inc_count;
        logic    set_status;
        t_status status;
        logic    capture_rd;
        logic    load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_read;
        logic full;
        logic pos_zero;
        logic key_gt;
        logic rank_ok;
    } t_stat;

endpackage

@@ rtl/spq_ram.sv @@
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spq_datapath.sv @@
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  spq_pkg::t_cmd                    i_cmd,
    output spq_pkg::t_stat                   o_stat,
    input  logic                             i_op,
    input  logic [spq_pkg::KEY_BITS-1:0]     i_key,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0] i_payload,
    input  logic [spq_pkg::RANK_BITS-1:0]    i_rank,
    output logic [spq_pkg::STATUS_BITS-1:0]  o_status,
    output logic [spq_pkg::KEY_BITS-1:0]     o_read_key,
    output logic [spq_pkg::PAYLOAD_BITS-1:0] o_read_payload,
    output logic [spq_pkg::COUNT_BITS-1:0]   o_count
);
    import spq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int RW  = (AW > RANK_BITS) ? AW : RANK_BITS;
    localparam int KW  = (CW > RANK_BITS) ? CW : RANK_BITS;
    localparam int XW  = (CW > COUNT_BITS) ? CW : COUNT_BITS;

    logic                    r_op;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [RANK_BITS-1:0]    r_rank;
    logic [CW-1:0]           r_pos;
    logic [CW-1:0]           r_count;
    t_status                 r_status;
    logic [KEY_BITS-1:0]     r_rd_key;
    logic [PAYLOAD_BITS-1:0] r_rd_payload;

    logic [STATUS_BITS-1:0]  r_out_status;
    logic [KEY_BITS-1:0]     r_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    logic [COUNT_BITS-1:0]   r_out_count;

    logic [ENTRY_BITS-1:0]   w_rdata;
    logic [ENTRY_BITS-1:0]   w_wdata;
    logic [AW-1:0]           w_raddr;
    logic [CW-1:0]           w_pos_m1;
    logic [RW-1:0]           w_rank_a;
    logic [KW-1:0]           w_rank_k;
    logic [KW-1:0]           w_count_k;
    logic [XW-1:0]           w_count_x;
    logic [KEY_BITS-1:0]     w_rkey;

    assign w_pos_m1  = r_pos - CW'(1);
    assign w_rank_a  = RW'(r_rank);
    assign w_rank_k  = KW'(r_rank);
    assign w_count_k = KW'(r_count);
    assign w_count_x = XW'(r_count);
    assign w_rkey    = w_rdata[ENTRY_BITS-1:PAYLOAD_BITS];

    // entries are stored as {key, payload}
    assign w_raddr = i_cmd.rd_rank ? w_rank_a[AW-1:0] : w_pos_m1[AW-1:0];
    assign w_wdata = i_cmd.wr_new ? {r_key, r_payload} : w_rdata;

    spq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_shift | i_cmd.wr_new),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_stat.op_read  = (r_op == OP_READ);
    assign o_stat.full     = (r_count >= CW'(DEPTH));
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.key_gt   = (r_key > w_rkey);
    assign o_stat.rank_ok  = (w_rank_k < w_count_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.inc_count) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op      <= i_op;
            r_key     <= i_key;
            r_payload <= i_payload;
            r_rank    <= i_rank;
        end
        if (i_cmd.init_pos) begin
            r_pos <= r_count;
        end else if (i_cmd.dec_pos) begin
            r_pos <= w_pos_m1;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.capture_rd) begin
            r_rd_key     <= w_rkey;
            r_rd_payload <= w_rdata[PAYLOAD_BITS-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_count  <= w_count_x[COUNT_BITS-1:0];
            if (r_status == ST_READ_OK) begin
                r_out_key     <= r_rd_key;
                r_out_payload <= r_rd_payload;
            end else begin
                r_out_key     <= '0;
                r_out_payload <= '0;
            end
        end
    end

    assign o_status       = r_out_status;
    assign o_read_key     = r_out_key;
    assign o_read_payload = r_out_payload;
    assign o_count        = r_out_count;

endmodule

@@ rtl/spq_ctrl.sv @@
module spq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd  o_cmd
);
    import spq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_SCAN_RD  = 6'b000100,
        S_SCAN_CMP = 6'b001000,
        S_READ_RD  = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_INSERTED;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op_read) begin
                    if (i_stat.rank_ok) begin
                        o_cmd.rd_rank = 1'b1;
                        n_state = S_READ_RD;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_RANK_BAD;
                        n_state = S_DONE;
                    end
                end else if (i_stat.full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.init_pos = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                // read address is pos-1 by default
                if (i_stat.pos_zero) begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.inc_count  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_INSERTED;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.key_gt) begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.dec_pos  = 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.inc_count  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_INSERTED;
                    n_state = S_DONE;
                end
            end
            S_READ_RD: begin
                o_cmd.capture_rd = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_READ_OK;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/sorted_insert_priority_queue.sv @@
// sorted insertion priority queue
//
// keeps up to DEPTH entries (key + payload) in descending key order; equal keys
// stay in arrival order. entries are never removed.
// input stream: tuser carries the op (insert or read at rank), tdata carries
// key, payload and rank. output stream: one result transfer per input transfer,
// tuser carries the status, tdata the read key, read payload and entry count.
// an insert walks up from the tail of the entry ram, one entry moved per step
// (registered read in S_SCAN_RD, then compare and write in S_SCAN_CMP).
// this read/compare/write step of the single-port-pair ram sets the insert rate;
// one item is in flight at a time and s_axis_tready is high only while the
// controller is idle.
// results sit in an output register: the next item is taken while a result
// waits, and that item's result is held back while m_axis_tready stays low.
// synchronous reset empties the queue (count back to zero) and drops any
// pending result; ram contents are left as they are
module sorted_insert_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [spq_pkg::S_TDATA_BITS-1:0] s_axis_tdata,  // key, payload, rank, zero pad
    input  logic                             s_axis_tuser,  // op
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [spq_pkg::M_TDATA_BITS-1:0] m_axis_tdata,  // read_key, read_payload, count, pad
    output logic [spq_pkg::STATUS_BITS-1:0]  m_axis_tuser   // status
);
    import spq_pkg::*;

    localparam int RANK_LO  = KEY_BITS + PAYLOAD_BITS;
    localparam int S_USED   = RANK_LO + RANK_BITS;
    localparam int M_USED   = KEY_BITS + PAYLOAD_BITS + COUNT_BITS;

    t_cmd                    w_cmd;
    t_stat                   w_stat;
    logic [KEY_BITS-1:0]     w_read_key;
    logic [PAYLOAD_BITS-1:0] w_read_payload;
    logic [COUNT_BITS-1:0]   w_count;

    // control: handshakes and sequencing of the insert walk
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // storage, position counter, compare and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_op           (s_axis_tuser),
        .i_key          (s_axis_tdata[KEY_BITS-1:0]),
        .i_payload      (s_axis_tdata[RANK_LO-1:KEY_BITS]),
        .i_rank         (s_axis_tdata[S_USED-1:RANK_LO]),
        .o_status       (m_axis_tuser),
        .o_read_key     (w_read_key),
        .o_read_payload (w_read_payload),
        .o_count        (w_count)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {{(M_TDATA_BITS - M_USED){1'b0}}, w_count, w_read_payload, w_read_key};

endmodule

@@ sim/tb_sorted_insert_priority_queue.sv @@
module tb_sorted_insert_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MIX_ITEMS    = 1990;
    localparam int QUIET_ITEMS  = 300;
    localparam int SETTLE_TICKS = 60;

    typedef struct {
        t_status                 status;
        logic [KEY_BITS-1:0]     rd_key;
        logic [PAYLOAD_BITS-1:0] rd_payload;
        logic [COUNT_BITS-1:0]   count;
    } t_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;  // key, payload, rank, zero pad
    logic                    s_tuser = OP_INSERT;  // op
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;  // read_key, read_payload, count, pad
    logic [STATUS_BITS-1:0]  m_tuser;  // status

    // software copy of the sorted store
    logic [KEY_BITS-1:0]     shadow_keys     [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] shadow_payloads [QUEUE_DEPTH];
    int                      shadow_count = 0;

    t_result pending_results[$];

    bit quiet_tail = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int inserted_seen = 0;
    int dropped_seen = 0;
    int read_ok_seen = 0;
    int read_bad_seen = 0;

    sorted_insert_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("tb_sorted_insert_priority_queue NOT OK");
            $finish;
        end
    end

    // expected result of one accepted transfer, applied to the shadow store
    function automatic void predict_queue_result(input t_op op,
                                                 input logic [KEY_BITS-1:0] key,
                                                 input logic [PAYLOAD_BITS-1:0] payload,
                                                 input logic [RANK_BITS-1:0] rank);
        t_result r;
        int      pos;
        r.rd_key     = '0;
        r.rd_payload = '0;
        if (op == OP_INSERT) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // entries with a strictly lower key move back one rank
                pos = shadow_count;
                while (pos > 0 && key > shadow_keys[pos-1]) begin
                    shadow_keys[pos]     = shadow_keys[pos-1];
                    shadow_payloads[pos] = shadow_payloads[pos-1];
                    pos--;
                end
                shadow_keys[pos]     = key;
                shadow_payloads[pos] = payload;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end else if (int'(rank) < shadow_count) begin
            r.status     = ST_READ_OK;
            r.rd_key     = shadow_keys[rank];
            r.rd_payload = shadow_payloads[rank];
        end else begin
            r.status = ST_RANK_BAD;
        end
        r.count = COUNT_BITS'(shadow_count);
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // result checker, samples the handshake as it stood before the edge
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result, status", 32'(m_tuser), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[KEY_BITS-1:0] != want.rd_key)
                    report_mismatch("read_key", 32'(m_tdata[KEY_BITS-1:0]),
                                    32'(want.rd_key));
                if (m_tdata[KEY_BITS+:PAYLOAD_BITS] != want.rd_payload)
                    report_mismatch("read_payload", m_tdata[KEY_BITS+:PAYLOAD_BITS],
                                    want.rd_payload);
                if (m_tdata[KEY_BITS+PAYLOAD_BITS+:COUNT_BITS] != want.count)
                    report_mismatch("count",
                                    32'(m_tdata[KEY_BITS+PAYLOAD_BITS+:COUNT_BITS]),
                                    32'(want.count));
                case (want.status)
                    ST_INSERTED: inserted_seen++;
                    ST_FULL:     dropped_seen++;
                    ST_READ_OK:  read_ok_seen++;
                    default:     read_bad_seen++;
                endcase
            end
        end
    end

    // result side back-pressure in random bursts, none in the quiet tail
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one input transfer; returns at the edge that accepted it
    task automatic send_item(input t_op op, input logic [KEY_BITS-1:0] key,
                             input logic [PAYLOAD_BITS-1:0] payload,
                             input logic [RANK_BITS-1:0] rank);
        logic [S_TDATA_BITS-1:0] word;
        word = '0;
        word[KEY_BITS-1:0]                      = key;
        word[KEY_BITS+:PAYLOAD_BITS]            = payload;
        word[KEY_BITS+PAYLOAD_BITS+:RANK_BITS]  = rank;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge i_clk); while (!s_tready);
        predict_queue_result(op, key, payload, rank);
    endtask

    // random gap on the input side
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // keys often drawn from a few values so that ties are common
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return KEY_BITS'($urandom_range(0, 2));
            1: return {KEY_BITS{1'b1}};
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    task automatic test_empty_reads();
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, {KEY_BITS{1'b1}}, {PAYLOAD_BITS{1'b1}}, {RANK_BITS{1'b1}});
    endtask

    // extreme keys and payloads, ties at both ends, then read every rank
    task automatic test_extremes();
        send_item(OP_INSERT, {KEY_BITS{1'b1}}, {PAYLOAD_BITS{1'b1}}, '0);
        send_item(OP_INSERT, '0, '0, {RANK_BITS{1'b1}});
        send_item(OP_INSERT, {KEY_BITS{1'b1}}, 32'h0000_0001, '0);
        send_item(OP_INSERT, '0, {PAYLOAD_BITS{1'b1}}, '0);
        send_item(OP_INSERT, 10'h200, 32'hA5A5_5A5A, '0);
        for (int r = 0; r <= 5; r++) begin
            sender_gap();
            send_item(OP_READ, '0, '0, RANK_BITS'(r));
        end
        send_item(OP_READ, '0, '0, {RANK_BITS{1'b1}});
    endtask

    // random inserts and reads until the store is full
    task automatic test_random_fill();
        while (shadow_count < QUEUE_DEPTH) begin
            sender_gap();
            if ($urandom_range(0, 1) == 0)
                send_item(OP_INSERT, pick_key(), $urandom, RANK_BITS'($urandom));
            else
                send_item(OP_READ, KEY_BITS'($urandom), $urandom, RANK_BITS'($urandom));
        end
    endtask

    // inserts into a full store are dropped, the first and last ranks stay readable
    task automatic test_full_store();
        send_item(OP_INSERT, {KEY_BITS{1'b1}}, {PAYLOAD_BITS{1'b1}}, '0);
        send_item(OP_INSERT, '0, '0, '0);
        send_item(OP_READ, '0, '0, {RANK_BITS{1'b1}});
        send_item(OP_READ, '0, '0, '0);
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < MIX_ITEMS; n++) begin
            if (n == MIX_ITEMS / 2)
                wait_drained();
            if (n == MIX_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            sender_gap();
            if ($urandom_range(0, 3) == 0)
                send_item(OP_INSERT, pick_key(), $urandom, RANK_BITS'($urandom));
            else
                send_item(OP_READ, KEY_BITS'($urandom), $urandom, RANK_BITS'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_reads();
        test_extremes();
        wait_drained();
        test_random_fill();
        wait_drained();
        test_full_store();
        test_random_mix();

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("ran %0d inserts, %0d drops on a full store, %0d reads in range, %0d past count",
                 inserted_seen, dropped_seen, read_ok_seen, read_bad_seen);
        $display("with random stalls on both sides and a stall-free tail, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_sorted_insert_priority_queue OK");
        end else begin
            $display("tb_sorted_insert_priority_queue NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/sorted_insert_priority_queue.sv
sim/tb_sorted_insert_priority_queue.sv
